// ===== hdl/ncst_pkg.sv =====
// Shared types and constants for the named counting semaphore table.
// Holds the request and response word layouts, operation and status codes,
// and the default sizes. Depends on nothing.
package ncst_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int NAME_BYTES_DEF = 8;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [2:0] OP_OPEN   = 3'd0;
	localparam logic [2:0] OP_WAIT   = 3'd1;
	localparam logic [2:0] OP_POST   = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_UNLINK = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic [63:0]        name_key;
		logic signed [15:0] initial_count;
		logic [5:0]         slot_index;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         result_slot;
		logic signed [15:0] count_out;
		logic               block_caller;
		logic               wake_waiter;
	} rsp_t;

endpackage

// ===== hdl/ncst_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
// Used for the name and count stores. Depends on nothing.
module ncst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/named_counting_semaphore_table.sv =====
// Top level of the named counting semaphore table: control sequencer around
// a name store and a count store. Depends on ncst_pkg and ncst_ram.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid, req_ready | req_t (operation, name, count, slot)
//   rsp     | out       | rsp_valid, rsp_ready | rsp_t (status, slot, count, flags)
//
// Path from the accepting edge to rsp_valid: open and unlink sweep the name
// store one slot a cycle in S_SCAN, then S_DRAIN, S_DECIDE (and S_COUNT when open
// finds its name and reads the count); wait, post and read pass S_COUNT; unknown
// operation or out-of-range slot goes straight to S_EMIT. After reset S_CLEAR
// clears both stores before the first word is accepted. One word is in flight;
// a finished result waits in S_EMIT until the output register is free.
module named_counting_semaphore_table import ncst_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam longint CMAX_L = (longint'(1) << (COUNT_BITS - 1)) - 1;
	localparam longint CMIN_L = -(longint'(1) << (COUNT_BITS - 1));
	localparam logic signed [32:0] CMAX = 33'(CMAX_L);
	localparam logic signed [32:0] CMIN = 33'(CMIN_L);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_COUNT  = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]                   state_q;
	logic [2:0]                   op_q;
	logic [63:0]                  name_q;
	logic signed [COUNT_BITS-1:0] init_q;
	logic [SLOT_W-1:0]            slot_q;
	logic [CNT_W-1:0]             scan_cnt_q;
	logic                         match_vld_q;
	logic [SLOT_W-1:0]            match_idx_q;
	logic                         empty_vld_q;
	logic [SLOT_W-1:0]            empty_idx_q;
	logic                         rd_vld_s1;
	logic [SLOT_W-1:0]            rd_addr_s1;
	rsp_t                         res_q;
	rsp_t                         rsp_q;
	logic                         rsp_valid_q;

	logic [63:0]                  name_trunc;
	logic signed [32:0]           init_ext;
	logic signed [COUNT_BITS-1:0] init_cl;
	logic                         idx_in_range;
	logic                         req_fire;
	logic                         scan_last;
	logic                         rsp_load;

	logic                         name_we;
	logic [SLOT_W-1:0]            name_waddr;
	logic [63:0]                  name_wdata;
	logic [SLOT_W-1:0]            name_raddr;
	logic [63:0]                  name_rdata;
	logic                         cnt_we;
	logic [SLOT_W-1:0]            cnt_waddr;
	logic [COUNT_BITS-1:0]        cnt_wdata;
	logic [SLOT_W-1:0]            cnt_raddr;
	logic [COUNT_BITS-1:0]        cnt_rdata;

	logic signed [COUNT_BITS-1:0] cur_cnt;
	logic signed [32:0]           cur_ext;
	logic signed [32:0]           dec_ext;
	logic signed [32:0]           inc_ext;
	logic signed [32:0]           nxt_ext;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign scan_last = (scan_cnt_q == CNT_W'(SLOTS - 1));
	assign rsp_load  = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);

	// A name ends at its first zero byte or after NAME_BYTES bytes.
	always_comb begin
		logic keep;
		keep = 1'b1;
		for (int b = 0; b < 8; b++) begin
			if (b >= NAME_BYTES || req.name_key[8*b +: 8] == 8'd0) begin
				keep = 1'b0;
			end
			name_trunc[8*b +: 8] = keep ? req.name_key[8*b +: 8] : 8'd0;
		end
	end

	assign init_ext = 33'(req.initial_count);
	always_comb begin
		if (init_ext > CMAX) begin
			init_cl = COUNT_BITS'(CMAX);
		end else if (init_ext < CMIN) begin
			init_cl = COUNT_BITS'(CMIN);
		end else begin
			init_cl = COUNT_BITS'(init_ext);
		end
	end

	assign idx_in_range = ({26'd0, req.slot_index} < 32'(SLOTS));

	// Saturating update of the addressed count.
	assign cur_cnt = cnt_rdata;
	assign cur_ext = 33'(cur_cnt);
	assign dec_ext = cur_ext - 33'sd1;
	assign inc_ext = cur_ext + 33'sd1;
	always_comb begin
		if (op_q == OP_WAIT) begin
			nxt_ext = (dec_ext < CMIN) ? CMIN : dec_ext;
		end else if (op_q == OP_POST) begin
			nxt_ext = (inc_ext > CMAX) ? CMAX : inc_ext;
		end else begin
			nxt_ext = cur_ext;
		end
	end

	// Store port control.
	always_comb begin
		name_we    = 1'b0;
		name_waddr = scan_cnt_q[SLOT_W-1:0];
		name_wdata = '0;
		name_raddr = scan_cnt_q[SLOT_W-1:0];
		cnt_we     = 1'b0;
		cnt_waddr  = scan_cnt_q[SLOT_W-1:0];
		cnt_wdata  = '0;
		cnt_raddr  = SLOT_W'(req.slot_index);
		unique case (state_q)
			S_CLEAR: begin
				name_we = 1'b1;
				cnt_we  = 1'b1;
			end
			S_DECIDE: begin
				cnt_raddr = match_idx_q;
				if (op_q == OP_OPEN && !match_vld_q && empty_vld_q) begin
					name_we    = 1'b1;
					name_waddr = empty_idx_q;
					name_wdata = name_q;
					cnt_we     = 1'b1;
					cnt_waddr  = empty_idx_q;
					cnt_wdata  = init_q;
				end else if (op_q == OP_UNLINK && match_vld_q) begin
					name_we   = 1'b1;
					name_waddr = match_idx_q;
					cnt_we    = 1'b1;
					cnt_waddr = match_idx_q;
				end
			end
			S_COUNT: begin
				cnt_we    = (op_q == OP_WAIT) || (op_q == OP_POST);
				cnt_waddr = slot_q;
				cnt_wdata = COUNT_BITS'(nxt_ext);
			end
			default: begin
			end
		endcase
	end

	ncst_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_waddr),
		.wdata (name_wdata),
		.raddr (name_raddr),
		.rdata (name_rdata)
	);

	ncst_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// Sweep compare: the first matching slot and the first empty slot win.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			match_vld_q <= 1'b0;
			empty_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			if (req_fire) begin
				match_vld_q <= 1'b0;
				empty_vld_q <= 1'b0;
			end else if (rd_vld_s1) begin
				if (!match_vld_q && name_rdata == name_q) begin
					match_vld_q <= 1'b1;
				end
				if (!empty_vld_q && name_rdata == 64'd0) begin
					empty_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= scan_cnt_q[SLOT_W-1:0];
		if (rd_vld_s1 && !match_vld_q && name_rdata == name_q) begin
			match_idx_q <= rd_addr_s1;
		end
		if (rd_vld_s1 && !empty_vld_q && name_rdata == 64'd0) begin
			empty_idx_q <= rd_addr_s1;
		end
	end

	// Sequencer and response staging.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			scan_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					if (scan_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					scan_cnt_q <= '0;
					if (req_fire) begin
						if (req.operation == OP_OPEN || req.operation == OP_UNLINK) begin
							state_q <= S_SCAN;
						end else if ((req.operation == OP_WAIT || req.operation == OP_POST ||
								req.operation == OP_READ) && idx_in_range) begin
							state_q <= S_COUNT;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_SCAN: begin
					scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (op_q == OP_OPEN && match_vld_q) begin
						state_q <= S_COUNT;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_COUNT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q   <= req.operation;
			name_q <= name_trunc;
			init_q <= init_cl;
			slot_q <= SLOT_W'(req.slot_index);
			res_q  <= '{status: ST_OK, result_slot: req.slot_index, count_out: 16'sd0,
				block_caller: 1'b0, wake_waiter: 1'b0};
		end
		if (state_q == S_DECIDE) begin
			if (match_vld_q) begin
				slot_q <= match_idx_q;
				res_q  <= '{status: ST_OK, result_slot: 6'(match_idx_q), count_out: 16'sd0,
					block_caller: 1'b0, wake_waiter: 1'b0};
			end else if (op_q == OP_OPEN && empty_vld_q) begin
				res_q <= '{status: ST_OK, result_slot: 6'(empty_idx_q), count_out: 16'(init_q),
					block_caller: 1'b0, wake_waiter: 1'b0};
			end else begin
				res_q <= '{status: (op_q == OP_OPEN) ? ST_FULL : ST_NOT_FOUND,
					result_slot: 6'd0, count_out: 16'sd0,
					block_caller: 1'b0, wake_waiter: 1'b0};
			end
		end
		if (state_q == S_COUNT) begin
			res_q.count_out    <= 16'(nxt_ext);
			res_q.block_caller <= (op_q == OP_WAIT) && (nxt_ext < 33'sd0);
			res_q.wake_waiter  <= (op_q == OP_POST) && (nxt_ext <= 33'sd0);
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

endmodule
